// File: hw/rtl/bse_pkg.sv
// shared types and tables for the baudot shift encoder
`timescale 1ns / 1ps

package bse_pkg;

  localparam int TABLE_LEN = 29;

  localparam int CHAR_W = 8;
  localparam int CODE_W = 5;

  // shift codes put on the line ahead of a character in the other mode
  localparam logic [CODE_W-1:0] SHIFT_LETTERS = 5'b11111;
  localparam logic [CODE_W-1:0] SHIFT_FIGURES = 5'b11011;
  localparam logic [CODE_W-1:0] CODE_UNKNOWN  = 5'b00000;

  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_LETTERS = 2'd1,
    MODE_FIGURES = 2'd2
  } shift_mode_t;

  // code for each table position, shared by both tables
  localparam logic [CODE_W-1:0] CODE_TABLE [0:TABLE_LEN-1] = '{
    5'h18, 5'h13, 5'h0E, 5'h12, 5'h10, 5'h16, 5'h0B, 5'h05, 5'h0C, 5'h1A,
    5'h1E, 5'h09, 5'h07, 5'h06, 5'h03, 5'h0D, 5'h1D, 5'h0A, 5'h14, 5'h01,
    5'h1C, 5'h0F, 5'h19, 5'h17, 5'h15, 5'h11, 5'h00, 5'h04, 5'h08
  };

  // A to Z, tab, space, newline
  localparam logic [CHAR_W-1:0] LETTER_TABLE [0:TABLE_LEN-1] = '{
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
    8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
    8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A, 8'h09, 8'h20, 8'h0A
  };

  // figures; the asterisk appears three times
  localparam logic [CHAR_W-1:0] FIGURE_TABLE [0:TABLE_LEN-1] = '{
    8'h2D, 8'h3F, 8'h3A, 8'h77, 8'h33, 8'h2A, 8'h2A, 8'h2A, 8'h38, 8'h62,
    8'h28, 8'h29, 8'h2E, 8'h2C, 8'h39, 8'h30, 8'h31, 8'h34, 8'h27, 8'h35,
    8'h37, 8'h3D, 8'h32, 8'h2F, 8'h36, 8'h2B, 8'h09, 8'h20, 8'h0A
  };

  typedef struct packed {
    logic              hit_letter;
    logic              hit_figure;
    logic [CODE_W-1:0] code;
  } lookup_t;

endpackage

// File: hw/rtl/bse_if.sv
// valid/ready channels for characters in and baudot codes out
`timescale 1ns / 1ps

interface bse_char_if;
  logic                       valid;
  logic                       ready;
  logic [bse_pkg::CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface bse_code_if;
  logic                       valid;
  logic                       ready;
  logic [bse_pkg::CODE_W-1:0] baudot_code;
  logic                       is_shift;
  logic                       last;

  modport source (output valid, output baudot_code, output is_shift, output last,
                  input ready);
  modport sink (input valid, input baudot_code, input is_shift, input last,
                output ready);
endinterface

// File: hw/rtl/bse_lookup.sv
// character to baudot code lookup in the letters and figures tables
`timescale 1ns / 1ps

module bse_lookup (
  input  logic [bse_pkg::CHAR_W-1:0] char_code,
  output bse_pkg::lookup_t           result
);

  logic                       hit_l;
  logic                       hit_f;
  logic [bse_pkg::CODE_W-1:0] code_l;
  logic [bse_pkg::CODE_W-1:0] code_f;

  // compare against every entry; later figure entries override earlier ones
  always_comb begin
    hit_l  = 1'b0;
    hit_f  = 1'b0;
    code_l = bse_pkg::CODE_UNKNOWN;
    code_f = bse_pkg::CODE_UNKNOWN;
    for (int i = 0; i < bse_pkg::TABLE_LEN; i++) begin
      if (bse_pkg::LETTER_TABLE[i] == char_code) begin
        hit_l  = 1'b1;
        code_l = bse_pkg::CODE_TABLE[i];
      end
      if (bse_pkg::FIGURE_TABLE[i] == char_code) begin
        hit_f  = 1'b1;
        code_f = bse_pkg::CODE_TABLE[i];
      end
    end
  end

  // letters take priority over figures
  always_comb begin
    result.hit_letter = hit_l;
    result.hit_figure = hit_f & ~hit_l;
    if (hit_l) begin
      result.code = code_l;
    end else if (hit_f) begin
      result.code = code_f;
    end else begin
      result.code = bse_pkg::CODE_UNKNOWN;
    end
  end

endmodule

// File: hw/rtl/baudot_shift_encoder_unit.sv
// Baudot shift encoder: one character in, a shift code when needed, then the character code.
// Latency: first result is valid in the cycle after the character is accepted.
// Throughput: one character per cycle while codes.ready holds; a character that changes the
// shift mode stalls input while the output register sends its shift code, then the held code.
// Reset (synchronous, rst high) sets the shift mode to neither and drops pending results.
`timescale 1ns / 1ps

module baudot_shift_encoder_unit (
  input logic       clk,
  input logic       rst,
  bse_char_if.sink  chars,
  bse_code_if.source codes
);

  bse_pkg::lookup_t           lk;
  bse_pkg::shift_mode_t       mode;
  bse_pkg::shift_mode_t       want;
  logic [bse_pkg::CODE_W-1:0] shift_code;
  logic                       found;
  logic                       need_shift;
  logic                       in_fire;
  logic                       out_fire;

  logic                       out_valid;
  logic [bse_pkg::CODE_W-1:0] out_code;
  logic                       out_shift;
  logic                       out_last;
  logic                       hold_valid;
  logic [bse_pkg::CODE_W-1:0] hold_code;

  bse_lookup u_lookup (
    .char_code (chars.char_code),
    .result    (lk)
  );

  // mode the character asks for and whether a shift code goes first
  always_comb begin
    found = lk.hit_letter | lk.hit_figure;
    if (lk.hit_letter) begin
      want       = bse_pkg::MODE_LETTERS;
      shift_code = bse_pkg::SHIFT_LETTERS;
    end else begin
      want       = bse_pkg::MODE_FIGURES;
      shift_code = bse_pkg::SHIFT_FIGURES;
    end
    need_shift = found & (mode != want);
  end

  // handshakes
  assign chars.ready = ~hold_valid & (~out_valid | codes.ready);
  assign in_fire     = chars.valid & chars.ready;
  assign out_fire    = out_valid & codes.ready;

  assign codes.valid       = out_valid;
  assign codes.baudot_code = out_code;
  assign codes.is_shift    = out_shift;
  assign codes.last        = out_last;

  // control: output valid, held second code, shift mode
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
      mode       <= bse_pkg::MODE_NONE;
    end else if (in_fire) begin
      out_valid  <= 1'b1;
      hold_valid <= need_shift;
      if (found) begin
        mode <= want;
      end
    end else if (out_fire) begin
      out_valid  <= hold_valid;
      hold_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_code <= lk.code;
      if (need_shift) begin
        out_code  <= shift_code;
        out_shift <= 1'b1;
        out_last  <= 1'b0;
      end else begin
        out_code  <= lk.code;
        out_shift <= 1'b0;
        out_last  <= 1'b1;
      end
    end else if (out_fire && hold_valid) begin
      out_code  <= hold_code;
      out_shift <= 1'b0;
      out_last  <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  // a held code always sits behind a shift code in the output register
  a_hold_behind_shift: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> (out_valid && out_shift && !out_last))
    else $error("held code without a shift code in front");

  // a shift item taken is followed at once by the character's final item
  a_shift_then_char: assert property (@(posedge clk) disable iff (rst)
    (codes.valid && codes.ready && codes.is_shift) |=>
      (codes.valid && !codes.is_shift && codes.last))
    else $error("shift code not followed by its character");

  // the shift code on the output matches the mode already taken
  a_shift_matches_mode: assert property (@(posedge clk) disable iff (rst)
    (codes.valid && codes.is_shift) |->
      ((codes.baudot_code == bse_pkg::SHIFT_LETTERS && mode == bse_pkg::MODE_LETTERS) ||
       (codes.baudot_code == bse_pkg::SHIFT_FIGURES && mode == bse_pkg::MODE_FIGURES)))
    else $error("shift code does not match shift mode");
`endif

endmodule

// File: tb/baudot_shift_encoder_unit_tb.sv
// self-checking testbench for the baudot shift encoder: directed cases, then random text
`timescale 1ns / 1ps

module baudot_shift_encoder_unit_tb;

  // one code on the output channel
  typedef struct packed {
    logic [bse_pkg::CODE_W-1:0] code;
    logic                       is_shift;
    logic                       last;
  } baudot_out_t;

  // directed case: character, and where typed in, the codes it must give
  typedef struct packed {
    logic [bse_pkg::CHAR_W-1:0] ch;
    logic                       typed;
    logic [1:0]                 n;
    baudot_out_t                first;
    baudot_out_t                second;
  } char_case_t;

  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 133;
  localparam int DRAIN_CYCLES = 8;

  localparam baudot_out_t NO_CODE      = '0;
  localparam baudot_out_t UNKNOWN_ITEM = '{bse_pkg::CODE_UNKNOWN, 1'b0, 1'b1};
  localparam baudot_out_t LETTERS_ITEM = '{bse_pkg::SHIFT_LETTERS, 1'b1, 1'b0};
  localparam baudot_out_t FIGURES_ITEM = '{bse_pkg::SHIFT_FIGURES, 1'b1, 1'b0};

  // codes of A to Z
  localparam logic [bse_pkg::CODE_W-1:0] LETTER_CODES [0:25] = '{
    5'h18, 5'h13, 5'h0E, 5'h12, 5'h10, 5'h16, 5'h0B, 5'h05, 5'h0C, 5'h1A,
    5'h1E, 5'h09, 5'h07, 5'h06, 5'h03, 5'h0D, 5'h1D, 5'h0A, 5'h14, 5'h01,
    5'h1C, 5'h0F, 5'h19, 5'h17, 5'h15, 5'h11
  };

  // distinct characters found only among the figures
  localparam logic [bse_pkg::CHAR_W-1:0] FIGURE_CHARS [0:23] = '{
    8'h2D, 8'h3F, 8'h3A, 8'h77, 8'h33, 8'h2A, 8'h38, 8'h62, 8'h28, 8'h29,
    8'h2E, 8'h2C, 8'h39, 8'h30, 8'h31, 8'h34, 8'h27, 8'h35, 8'h37, 8'h3D,
    8'h32, 8'h2F, 8'h36, 8'h2B
  };

  localparam char_case_t DIRECTED_CASES [0:21] = '{
    '{8'h00, 1'b1, 2'd1, UNKNOWN_ITEM, NO_CODE},           // unknown right after reset
    '{8'h41, 1'b1, 2'd2, LETTERS_ITEM, '{5'h18, 1'b0, 1'b1}},
    '{8'h5A, 1'b1, 2'd1, '{5'h11, 1'b0, 1'b1}, NO_CODE},
    '{8'hFF, 1'b1, 2'd1, UNKNOWN_ITEM, NO_CODE},
    '{8'h2D, 1'b1, 2'd2, FIGURES_ITEM, '{5'h18, 1'b0, 1'b1}},
    '{8'h2A, 1'b1, 2'd1, '{5'h05, 1'b0, 1'b1}, NO_CODE},   // asterisk, last entry wins
    '{8'h09, 1'b1, 2'd2, LETTERS_ITEM, '{5'h00, 1'b0, 1'b1}}, // tab goes to letters
    '{8'h77, 1'b1, 2'd2, FIGURES_ITEM, '{5'h12, 1'b0, 1'b1}},
    '{8'h20, 1'b1, 2'd2, LETTERS_ITEM, '{5'h04, 1'b0, 1'b1}},
    '{8'h62, 1'b1, 2'd2, FIGURES_ITEM, '{5'h1A, 1'b0, 1'b1}},
    '{8'h80, 1'b1, 2'd1, UNKNOWN_ITEM, NO_CODE},           // mode stays figures
    '{8'h2B, 1'b0, 2'd0, NO_CODE, NO_CODE},
    '{8'h0A, 1'b1, 2'd2, LETTERS_ITEM, '{5'h08, 1'b0, 1'b1}},
    '{8'h61, 1'b1, 2'd1, UNKNOWN_ITEM, NO_CODE},           // lowercase a
    '{8'h45, 1'b0, 2'd0, NO_CODE, NO_CODE},
    '{8'h7F, 1'b1, 2'd1, UNKNOWN_ITEM, NO_CODE},
    '{8'h39, 1'b0, 2'd0, NO_CODE, NO_CODE},
    '{8'h51, 1'b0, 2'd0, NO_CODE, NO_CODE},
    '{8'h30, 1'b0, 2'd0, NO_CODE, NO_CODE},
    '{8'h2F, 1'b0, 2'd0, NO_CODE, NO_CODE},
    '{8'h57, 1'b0, 2'd0, NO_CODE, NO_CODE},
    '{8'hAA, 1'b1, 2'd1, UNKNOWN_ITEM, NO_CODE}
  };

  localparam int IDLE_PCT  [0:3] = '{0, 57, 0, 31};
  localparam int STALL_PCT [0:3] = '{0, 0, 57, 31};

  logic clk = 1'b0;
  logic rst;

  bse_char_if char_ch ();
  bse_code_if code_ch ();

  baudot_shift_encoder_unit u_dut (
    .clk   (clk),
    .rst   (rst),
    .chars (char_ch),
    .codes (code_ch)
  );

  bse_pkg::shift_mode_t line_mode = bse_pkg::MODE_NONE;
  baudot_out_t encoded[$];
  baudot_out_t expected_codes[$];
  int          idle_pct   = 0;
  int          stall_pct  = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          char_group = 0;

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // encode one character into the codes it gives, tracking the line mode
  function automatic void encode_char(input logic [bse_pkg::CHAR_W-1:0] ch);
    bse_pkg::shift_mode_t       want;
    logic [bse_pkg::CODE_W-1:0] code;
    baudot_out_t                item;
    want = bse_pkg::MODE_NONE;
    code = bse_pkg::CODE_UNKNOWN;
    encoded.delete();
    case (ch)
      8'h09: begin want = bse_pkg::MODE_LETTERS; code = 5'h00; end
      8'h20: begin want = bse_pkg::MODE_LETTERS; code = 5'h04; end
      8'h0A: begin want = bse_pkg::MODE_LETTERS; code = 5'h08; end
      default: ;
    endcase
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      want = bse_pkg::MODE_LETTERS;
      code = LETTER_CODES[5'(ch - 8'h41)];
    end
    if (want == bse_pkg::MODE_NONE) begin
      want = bse_pkg::MODE_FIGURES;
      case (ch)
        8'h2D: code = 5'h18;
        8'h3F: code = 5'h13;
        8'h3A: code = 5'h0E;
        8'h77: code = 5'h12;
        8'h33: code = 5'h10;
        8'h2A: code = 5'h05;
        8'h38: code = 5'h0C;
        8'h62: code = 5'h1A;
        8'h28: code = 5'h1E;
        8'h29: code = 5'h09;
        8'h2E: code = 5'h07;
        8'h2C: code = 5'h06;
        8'h39: code = 5'h03;
        8'h30: code = 5'h0D;
        8'h31: code = 5'h1D;
        8'h34: code = 5'h0A;
        8'h27: code = 5'h14;
        8'h35: code = 5'h01;
        8'h37: code = 5'h1C;
        8'h3D: code = 5'h0F;
        8'h32: code = 5'h19;
        8'h2F: code = 5'h17;
        8'h36: code = 5'h15;
        8'h2B: code = 5'h11;
        default: want = bse_pkg::MODE_NONE;
      endcase
    end
    // unknown character: a single zero code, mode untouched
    if (want == bse_pkg::MODE_NONE) begin
      encoded.push_back(UNKNOWN_ITEM);
      return;
    end
    if (line_mode != want) begin
      line_mode = want;
      encoded.push_back((want == bse_pkg::MODE_LETTERS) ? LETTERS_ITEM : FIGURES_ITEM);
    end
    item.code     = code;
    item.is_shift = 1'b0;
    item.last     = 1'b1;
    encoded.push_back(item);
  endfunction

  // random text: runs of letters or figures, with some raw bytes mixed in
  function automatic logic [bse_pkg::CHAR_W-1:0] pick_char();
    int idx;
    if ($urandom_range(0, 99) < 20) return 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 30) char_group = 1 - char_group;
    if (char_group == 0) begin
      idx = $urandom_range(0, 28);
      if (idx < 26) return 8'h41 + 8'(idx);
      if (idx == 26) return 8'h09;
      if (idx == 27) return 8'h20;
      return 8'h0A;
    end
    return FIGURE_CHARS[$urandom_range(0, 23)];
  endfunction

  // offer one character, return once it is accepted
  task automatic send_char(input logic [bse_pkg::CHAR_W-1:0] ch);
    while ($urandom_range(0, 99) < idle_pct) begin
      char_ch.valid <= 1'b0;
      @(posedge clk);
    end
    char_ch.valid     <= 1'b1;
    char_ch.char_code <= ch;
    @(posedge clk);
    while (!char_ch.ready) @(posedge clk);
  endtask

  // hold off the sender until every expected code is out
  task automatic drain_codes();
    char_ch.valid <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk);
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    code_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // compare each output item with the oldest expectation
  always @(posedge clk) begin : check_codes
    baudot_out_t got;
    baudot_out_t want;
    if (!rst && code_ch.valid && code_ch.ready) begin
      got = '{code_ch.baudot_code, code_ch.is_shift, code_ch.last};
      if (expected_codes.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected code %h shift %b last %b", got.code, got.is_shift, got.last);
        mismatches++;
      end else begin
        want = expected_codes.pop_front();
        if (got !== want) begin
          if (mismatches < 10)
            $display("mismatch: code %h shift %b last %b, want code %h shift %b last %b",
                     got.code, got.is_shift, got.last, want.code, want.is_shift, want.last);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((char_ch.valid && char_ch.ready) || (code_ch.valid && code_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("baudot_shift_encoder_unit verification failed");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    char_case_t                 row;
    logic [bse_pkg::CHAR_W-1:0] ch;
    rst               = 1'b1;
    char_ch.valid     = 1'b0;
    char_ch.char_code = '0;
    code_ch.ready     = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed cases, no idling
    foreach (DIRECTED_CASES[i]) begin
      row = DIRECTED_CASES[i];
      send_char(row.ch);
      encode_char(row.ch);
      if (row.typed) begin
        expected_codes.push_back(row.first);
        if (row.n == 2'd2) expected_codes.push_back(row.second);
      end else begin
        foreach (encoded[k]) expected_codes.push_back(encoded[k]);
      end
    end
    drain_codes();

    // random text under each idling mix, draining between phases
    for (int p = 0; p < 4; p++) begin
      idle_pct  = IDLE_PCT[p];
      stall_pct = STALL_PCT[p];
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        ch = pick_char();
        send_char(ch);
        encode_char(ch);
        foreach (encoded[k]) expected_codes.push_back(encoded[k]);
      end
      drain_codes();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("baudot_shift_encoder_unit verification clean");
    else
      $display("baudot_shift_encoder_unit verification failed");
    $finish;
  end

endmodule
